### src/cbpa_pkg.sv
// ----------------------------------------------------------------------------
// Channel bin packing allocator package
// Shared item types, candidate token, cell control and slot length table.
// ----------------------------------------------------------------------------
package cbpa_pkg;

	// Item operations
	localparam logic OP_REFILL = 1'b0;
	localparam logic OP_PLACE  = 1'b1;

	// Fit policy codes
	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	// Widths and fixed values
	localparam int CHAN_IDX_W = 4;             // up to 16 channels
	localparam int CAP_W      = 17;
	localparam int LOAD_W     = 25;
	localparam int DEN_W      = 26;            // 1000 * period
	localparam int PROD_W     = 19;            // slot * work
	localparam int DIV_STEPS  = 25;            // quotient bits kept
	localparam int CNT_W      = 5;

	localparam logic [CAP_W-1:0]  FULL_CAPACITY = 17'd65536;
	localparam logic [LOAD_W-1:0] LOAD_MAX      = 25'd33554431;
	localparam logic [DEN_W-1:0]  DEN_SCALE     = 26'd1000;

	typedef struct packed {
		logic        operation;
		logic [9:0]  node_id;
		logic [7:0]  work_time;
		logic [15:0] period;
		logic [2:0]  lowest_channel;
		logic        last_node;
	} cbpa_in_t;

	typedef struct packed {
		logic [9:0]        placed_id;
		logic              placed;
		logic [2:0]        chosen_channel;
		logic [LOAD_W-1:0] node_load;
		logic [CAP_W-1:0]  capacity_left;
		logic              batch_done;
	} cbpa_out_t;

	// Best candidate so far, handed from cell to cell during the scan
	typedef struct packed {
		logic                  found;
		logic [CHAN_IDX_W-1:0] chan;
		logic [LOAD_W-1:0]     cost;
		logic [CAP_W-1:0]      cap_left;
		logic [LOAD_W-1:0]     base_cost;   // cost on channel 0
	} cbpa_token_t;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic                  load;
		logic                  step;
		logic                  fill;
		logic                  commit;
		logic [CHAN_IDX_W-1:0] commit_chan;
		logic [CAP_W-1:0]      commit_left;
		logic [1:0]            policy;
	} cbpa_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_START,
		ST_SCAN,
		ST_COMMIT
	} cbpa_state_t;

	// Slot length per channel, indexed by channel mod 6
	function automatic logic [10:0] slot_len(input int unsigned sel);
		logic [10:0] val;
		case (sel)
			0: val = 11'd1810;
			1: val = 11'd987;
			2: val = 11'd493;
			3: val = 11'd267;
			4: val = 11'd154;
			5: val = 11'd82;
			default: val = 11'd0;
		endcase
		return val;
	endfunction

endpackage

### src/channel_bin_packing_allocator_unit.sv
// ----------------------------------------------------------------------------
// Channel bin packing allocator
// Places nodes onto channels by first, best or worst fit over a cell row.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one item. A refill item (operation 0)
//   sets every channel back to full capacity at its transfer and gives no
//   result. A place item (operation 1) gives one result on
//   out_valid/out_ready/out_data.
//   cfg_valid/cfg_ready/cfg_data write the fit policy (0 first, 1 best,
//   2 worst, 3 acts as first); cfg_ready is always high. Write only while
//   the block is idle.
//   A place item passes, from its transfer to out_valid, through a load
//   state, a divide state in which every cell computes one quotient bit
//   of its own cost per cycle, a start state that launches the scan, a
//   scan in which the candidate token moves down the row one cell per
//   cycle, and a commit state. One item is handled at a time; the next
//   item can be taken in the cycle after the commit.
//   The result sits in an output register. If the receiver stalls, the
//   block still accepts and works the next item, and holds in its commit
//   cycle only while the previous result has not been taken.
//   Reset sets all capacities to full and the policy to best fit.
// ----------------------------------------------------------------------------
module channel_bin_packing_allocator_unit
	import cbpa_pkg::*;
#(
	parameter int CHANNELS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  cbpa_in_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output cbpa_out_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data
);

	cbpa_state_t       state_q;
	cbpa_state_t       state_nxt;
	logic [1:0]        policy_q;
	cbpa_in_t          node_q;
	logic [DEN_W-1:0]  den_q;
	logic              zero_q;
	logic [CNT_W-1:0]  div_cnt_q;
	logic              out_valid_q;
	cbpa_out_t         out_q;

	logic              in_xfer;
	logic              out_free;
	logic              div_last;
	logic              go_start;
	cbpa_ctrl_t        ctrl;
	logic [CHANNELS:0] go_w;
	cbpa_token_t       tok_w [CHANNELS+1];
	cbpa_token_t       final_tok;

	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign div_last  = (div_cnt_q == CNT_W'(DIV_STEPS - 1));
	assign final_tok = tok_w[CHANNELS];
	assign cfg_ready = 1'b1;

	// Policy register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_BEST;
		end else if (cfg_valid && cfg_ready) begin
			policy_q <= cfg_data;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && in_data.operation == OP_PLACE) begin
					state_nxt = ST_LOAD;
				end
			end
			ST_LOAD: state_nxt = ST_DIV;
			ST_DIV: begin
				if (div_last) begin
					state_nxt = ST_START;
				end
			end
			ST_START: state_nxt = ST_SCAN;
			ST_SCAN: begin
				if (go_w[CHANNELS]) begin
					state_nxt = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready         = (state_q == ST_IDLE);
		go_start         = (state_q == ST_START);
		ctrl.load        = (state_q == ST_LOAD);
		ctrl.step        = (state_q == ST_DIV);
		ctrl.fill        = (state_q == ST_IDLE) && in_valid &&
			in_data.operation == OP_REFILL;
		ctrl.commit      = (state_q == ST_COMMIT) && out_free && final_tok.found;
		ctrl.commit_chan = final_tok.chan;
		ctrl.commit_left = final_tok.cap_left;
		ctrl.policy      = policy_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Node fields and divisor, taken at the transfer
	always_ff @(posedge clk) begin
		if (in_xfer && in_data.operation == OP_PLACE) begin
			node_q <= in_data;
			den_q  <= DEN_W'(in_data.period) * DEN_SCALE;
			zero_q <= (in_data.period == 16'd0);
		end
	end

	// Divide step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (state_q == ST_LOAD) begin
			div_cnt_q <= '0;
		end else if (state_q == ST_DIV) begin
			div_cnt_q <= div_cnt_q + CNT_W'(1);
		end
	end

	// Cell row
	assign go_w[0]  = go_start;
	assign tok_w[0] = '0;

	for (genvar k = 0; k < CHANNELS; k++) begin : g_cell
		cbpa_cell #(
			.INDEX(k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.work       (node_q.work_time),
			.den        (den_q),
			.zero_period(zero_q),
			.low        (node_q.lowest_channel),
			.go_in      (go_w[k]),
			.tok_in     (tok_w[k]),
			.go_out     (go_w[k+1]),
			.tok_out    (tok_w[k+1])
		);
	end

	// Result register
	always_ff @(posedge clk) begin
		if (state_q == ST_COMMIT && out_free) begin
			out_q.placed_id  <= node_q.node_id;
			out_q.batch_done <= node_q.last_node;
			out_q.placed     <= final_tok.found;
			if (final_tok.found) begin
				out_q.chosen_channel <= final_tok.chan[2:0];
				out_q.node_load      <= final_tok.cost;
				out_q.capacity_left  <= final_tok.cap_left;
			end else begin
				out_q.chosen_channel <= 3'd0;
				out_q.node_load      <= final_tok.base_cost;
				out_q.capacity_left  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_COMMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(go_w))
		else $error("more than one scan token in the cell row");

	a_idle_no_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (go_w == '0))
		else $error("scan token active while taking items");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_cnt_q < CNT_W'(DIV_STEPS)))
		else $error("divide step count overran");

	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT && out_free) |=> out_valid_q)
		else $error("commit did not present a result");

endmodule

### src/cbpa_cell.sv
// ----------------------------------------------------------------------------
// Channel cell
// Holds one channel's capacity, divides out the node cost one quotient bit
// per cycle, and folds itself into the candidate token passing down the row.
// ----------------------------------------------------------------------------
module cbpa_cell
	import cbpa_pkg::*;
#(
	parameter int INDEX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cbpa_ctrl_t        ctrl,
	input  logic [7:0]        work,
	input  logic [DEN_W-1:0]  den,
	input  logic              zero_period,
	input  logic [2:0]        low,
	input  logic              go_in,
	input  cbpa_token_t       tok_in,
	output logic              go_out,
	output cbpa_token_t       tok_out
);

	localparam logic [10:0]           SLOT   = slot_len(INDEX % 6);
	localparam logic [CHAN_IDX_W-1:0] MY_IDX = CHAN_IDX_W'(INDEX);
	localparam bit                    FIRST  = (INDEX == 0);

	logic [CAP_W-1:0]  cap_q;
	logic [DEN_W-1:0]  rem_q;
	logic [24:0]       numlo_q;
	logic [LOAD_W-1:0] quo_q;
	logic              go_q;
	cbpa_token_t       tok_q;

	logic [PROD_W-1:0] prod;
	logic [DEN_W:0]    shifted;
	logic [DEN_W+1:0]  diff;
	logic              ge;
	logic [LOAD_W-1:0] cost;
	logic [CAP_W-1:0]  cap_left;
	logic              eligible;
	logic              take;
	cbpa_token_t       tok_nxt;

	// Numerator is slot * work * 65536; the top ten bits start the remainder
	assign prod    = PROD_W'(SLOT) * PROD_W'(work);
	assign shifted = {rem_q, numlo_q[24]};
	assign diff    = {1'b0, shifted} - {2'b0, den};
	assign ge      = ~diff[DEN_W+1];

	// Divider register: one restoring step per cycle
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_q   <= {16'b0, prod[18:9]};
			numlo_q <= {prod[8:0], 16'b0};
			quo_q   <= '0;
		end else if (ctrl.step) begin
			rem_q   <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			numlo_q <= {numlo_q[23:0], 1'b0};
			quo_q   <= {quo_q[LOAD_W-2:0], ge};
		end
	end

	// Scan evaluation against the incoming best candidate
	always_comb begin
		cost     = zero_period ? LOAD_MAX : quo_q;
		eligible = (MY_IDX >= {1'b0, low}) && (cost <= {8'b0, cap_q});
		cap_left = cap_q - cost[CAP_W-1:0];
		take     = eligible && (!tok_in.found ||
			(ctrl.policy == POL_BEST  && cap_left < tok_in.cap_left) ||
			(ctrl.policy == POL_WORST && cap_left > tok_in.cap_left));
		tok_nxt  = tok_in;
		if (take) begin
			tok_nxt.found    = 1'b1;
			tok_nxt.chan     = MY_IDX;
			tok_nxt.cost     = cost;
			tok_nxt.cap_left = cap_left;
		end
		if (FIRST) begin
			tok_nxt.base_cost = cost;
		end
	end

	always_ff @(posedge clk) begin
		if (go_in) begin
			tok_q <= tok_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q <= 1'b0;
		end else begin
			go_q <= go_in;
		end
	end

	// Capacity: refill or commit of the chosen channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= FULL_CAPACITY;
		end else if (ctrl.fill) begin
			cap_q <= FULL_CAPACITY;
		end else if (ctrl.commit && ctrl.commit_chan == MY_IDX) begin
			cap_q <= ctrl.commit_left;
		end
	end

	assign go_out  = go_q;
	assign tok_out = tok_q;

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Channel bin packing allocator testbench
// Drives refill and place items with random gaps and output stalls. Each result is
// checked field by field against the result its directed row carries, or else a
// cycle-free placement predictor run under all four fit policy codes. A short table
// of directed items comes first, then random node batches with some noise items mixed in.
// ----------------------------------------------------------------------------
module testbench;
	import cbpa_pkg::*;

	localparam int          CHANNELS   = 8;
	localparam logic [1:0]  POL_SPARE  = 2'd3;        // unused code, acts as first fit
	localparam int          IDLE_MAX   = 16;
	localparam int          SETTLE_CYC = 40;          // a little over the time one place item takes
	localparam int          LONG_HOLD  = 400;
	localparam int unsigned SLOT_LEN [6] = '{1810, 987, 493, 267, 154, 82};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	cbpa_in_t   in_data;
	logic       out_valid;
	logic       out_ready;
	cbpa_out_t  out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_data;

	// Predictor state
	logic [CAP_W-1:0] chan_cap [CHANNELS];
	logic [1:0]       policy_now;
	cbpa_out_t        pending_placements [$];

	int mismatch_count = 0;
	int hold_len       = 0;
	bit no_idle        = 1'b0;

	// Directed items; rows with want_set carry a result read straight off the rules
	typedef struct packed {
		cbpa_in_t  item;
		logic      want_set;
		cbpa_out_t want;
	} dir_row_t;

	dir_row_t dir_table [17] = '{
		// zero work fits channel 0 on a full row
		'{'{OP_PLACE, 10'd0, 8'd0, 16'd1, 3'd0, 1'b0}, 1'b1,
			'{10'd0, 1'b1, 3'd0, 25'd0, 17'd65536, 1'b0}},
		// zero period saturates the cost everywhere
		'{'{OP_PLACE, 10'd1023, 8'd255, 16'd0, 3'd7, 1'b1}, 1'b1,
			'{10'd1023, 1'b0, 3'd0, LOAD_MAX, 17'd0, 1'b1}},
		// heaviest node fits nowhere, cost on channel 0 reported
		'{'{OP_PLACE, 10'd2, 8'd255, 16'd1, 3'd0, 1'b0}, 1'b1,
			'{10'd2, 1'b0, 3'd0, 25'd30248140, 17'd0, 1'b0}},
		// top channel as the only one allowed
		'{'{OP_PLACE, 10'd3, 8'd0, 16'd65535, 3'd7, 1'b0}, 1'b1,
			'{10'd3, 1'b1, 3'd7, 25'd0, 17'd65536, 1'b0}},
		'{'{OP_PLACE, 10'd4, 8'd50, 16'd100, 3'd0, 1'b0}, 1'b0, '0},
		'{'{OP_PLACE, 10'd5, 8'd50, 16'd100, 3'd0, 1'b0}, 1'b0, '0},
		'{'{OP_PLACE, 10'd6, 8'd1, 16'd65535, 3'd0, 1'b0}, 1'b0, '0},
		'{'{OP_PLACE, 10'd7, 8'd255, 16'd65535, 3'd3, 1'b1}, 1'b0, '0},
		'{'{OP_PLACE, 10'd8, 8'd200, 16'd400, 3'd5, 1'b0}, 1'b0, '0},
		'{'{OP_PLACE, 10'd9, 8'd128, 16'd1000, 3'd2, 1'b0}, 1'b0, '0},
		'{'{OP_PLACE, 10'd10, 8'd255, 16'd32768, 3'd4, 1'b0}, 1'b0, '0},
		'{'{OP_PLACE, 10'd11, 8'd85, 16'd2, 3'd1, 1'b0}, 1'b0, '0},
		'{'{OP_REFILL, 10'd12, 8'd255, 16'd65535, 3'd7, 1'b1}, 1'b0, '0},
		'{'{OP_PLACE, 10'd13, 8'd1, 16'd1, 3'd6, 1'b0}, 1'b0, '0},
		// zero work with zero period: period wins, nothing fits
		'{'{OP_PLACE, 10'd14, 8'd0, 16'd0, 3'd0, 1'b0}, 1'b1,
			'{10'd14, 1'b0, 3'd0, LOAD_MAX, 17'd0, 1'b0}},
		'{'{OP_PLACE, 10'd682, 8'hAA, 16'h5555, 3'd5, 1'b1}, 1'b0, '0},
		'{'{OP_PLACE, 10'd341, 8'h55, 16'hAAAA, 3'd2, 1'b0}, 1'b0, '0}
	};

	channel_bin_packing_allocator_unit #(
		.CHANNELS(CHANNELS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit, well past the slowest legal run
	initial begin
		#3000000;
		$display("testbench: errors");
		$finish;
	end

	// Q16 cost of a node on channel k, saturated
	function automatic logic [LOAD_W-1:0] node_cost(input int unsigned k,
			input logic [7:0] work, input logic [15:0] period);
		longint unsigned num;
		longint unsigned den;
		longint unsigned q;
		if (period == 16'd0)
			return LOAD_MAX;
		num = longint'(SLOT_LEN[k % 6]) * longint'(work) * 64'd65536;
		den = 64'd1000 * longint'(period);
		q = num / den;
		if (q > longint'(LOAD_MAX))
			q = longint'(LOAD_MAX);
		return LOAD_W'(q);
	endfunction

	// Applies one item to the predictor; returns 1 when a result is due
	function automatic bit model_step(input cbpa_in_t item, output cbpa_out_t res);
		logic              found;
		logic              stop;
		logic              take;
		int unsigned       pick;
		logic [LOAD_W-1:0] c;
		logic [LOAD_W-1:0] pick_cost;
		logic [CAP_W-1:0]  left;
		logic [CAP_W-1:0]  pick_left;
		res = '0;
		if (item.operation == OP_REFILL) begin
			foreach (chan_cap[k])
				chan_cap[k] = FULL_CAPACITY;
			return 1'b0;
		end
		found = 1'b0;
		stop = 1'b0;
		pick = 0;
		pick_cost = '0;
		pick_left = '0;
		for (int unsigned k = 0; k < CHANNELS && !stop; k++) begin
			c = node_cost(k, item.work_time, item.period);
			if (k >= item.lowest_channel && c <= LOAD_W'(chan_cap[k])) begin
				left = chan_cap[k] - CAP_W'(c);
				case (policy_now)
					POL_BEST:  take = !found || left < pick_left;
					POL_WORST: take = !found || left > pick_left;
					default:   take = !found;
				endcase
				if (take) begin
					found = 1'b1;
					pick = k;
					pick_cost = c;
					pick_left = left;
				end
				// first fit stops at the first channel that holds the node
				if (found && policy_now != POL_BEST && policy_now != POL_WORST)
					stop = 1'b1;
			end
		end
		res.placed_id = item.node_id;
		res.batch_done = item.last_node;
		if (found) begin
			chan_cap[pick] = pick_left;
			res.placed = 1'b1;
			res.chosen_channel = 3'(pick);
			res.node_load = pick_cost;
			res.capacity_left = pick_left;
		end else begin
			res.node_load = node_cost(0, item.work_time, item.period);
		end
		return 1'b1;
	endfunction

	// One input transfer, then the predictor update
	task automatic send_item(input cbpa_in_t item, input logic want_set,
			input cbpa_out_t want);
		int        gap;
		cbpa_out_t res;
		gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		if (model_step(item, res))
			pending_placements.insert(pending_placements.size(), want_set ? want : res);
	endtask

	// Policy write once the block has gone quiet
	task automatic write_policy(input logic [1:0] pol);
		in_valid <= 1'b0;
		while (pending_placements.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= pol;
		do @(posedge clk); while (!cfg_ready);
		policy_now = pol;
		cfg_valid <= 1'b0;
	endtask

	// Mostly refill-led batches sorted by falling utilization, some noise
	task automatic run_phase(input int n_items);
		int       sent;
		int       n_nodes;
		int       pos;
		cbpa_in_t node;
		cbpa_in_t batch [$];
		sent = 0;
		while (sent < n_items) begin
			no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 6) == 0) begin
				node.operation = 1'($urandom);
				node.node_id = 10'($urandom);
				node.work_time = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom);
				node.period = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
				node.lowest_channel = 3'($urandom);
				node.last_node = 1'($urandom);
				send_item(node, 1'b0, '0);
				sent++;
			end else begin
				batch.delete();
				n_nodes = $urandom_range(3, 12);
				for (int i = 0; i < n_nodes; i++) begin
					node.operation = OP_PLACE;
					node.node_id = 10'($urandom);
					node.work_time = 8'($urandom_range(0, 255));
					node.period = 16'($urandom_range(1, 2000));
					node.lowest_channel = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'd0;
					node.last_node = 1'b0;
					pos = 0;
					while (pos < batch.size() && longint'(batch[pos].work_time) *
							node.period >= longint'(node.work_time) * batch[pos].period)
						pos++;
					batch.insert(pos, node);
				end
				batch[batch.size()-1].last_node = 1'b1;
				node = batch[0];
				node.operation = OP_REFILL;
				send_item(node, 1'b0, '0);
				foreach (batch[i])
					send_item(batch[i], 1'b0, '0);
				sent += n_nodes + 1;
			end
		end
		no_idle = 1'b0;
	endtask

	// Result side: random stalls, the odd long hold, and the check of each transfer
	initial begin : result_side
		int        stall;
		cbpa_out_t got;
		cbpa_out_t want;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_len > 0) begin
				stall = hold_len;
				hold_len = 0;
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got = out_data;
			if (pending_placements.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result with nothing pending: id %0d placed %0b chan %0d",
						got.placed_id, got.placed, got.chosen_channel);
			end else begin
				want = pending_placements.pop_front();
				if (got.placed_id !== want.placed_id || got.placed !== want.placed ||
						got.chosen_channel !== want.chosen_channel ||
						got.node_load !== want.node_load ||
						got.capacity_left !== want.capacity_left ||
						got.batch_done !== want.batch_done) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch: expected id %0d placed %0b chan %0d load %0d left %0d done %0b",
							want.placed_id, want.placed, want.chosen_channel,
							want.node_load, want.capacity_left, want.batch_done);
						$display("  got id %0d placed %0b chan %0d load %0d left %0d done %0b",
							got.placed_id, got.placed, got.chosen_channel,
							got.node_load, got.capacity_left, got.batch_done);
					end
				end
			end
		end
	end

	// Stimulus and run control
	initial begin : stimulus
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		foreach (chan_cap[k])
			chan_cap[k] = FULL_CAPACITY;
		policy_now = POL_BEST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under the reset policy
		foreach (dir_table[i])
			send_item(dir_table[i].item, dir_table[i].want_set, dir_table[i].want);

		write_policy(POL_FIRST);
		run_phase(120);
		// receiver holds off so the block backs up into its input
		write_policy(POL_WORST);
		hold_len = LONG_HOLD;
		run_phase(120);
		write_policy(POL_SPARE);
		run_phase(100);
		write_policy(POL_BEST);
		run_phase(120);
		write_policy(2'($urandom_range(0, 3)));
		run_phase(120);

		// drain and let the last item settle
		in_valid <= 1'b0;
		while (pending_placements.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		if (mismatch_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

### files.f
src/cbpa_pkg.sv
src/cbpa_cell.sv
src/channel_bin_packing_allocator_unit.sv
verif/testbench.sv
